### hdl/gtg_pkg.sv
// Shared types, constants and the arctangent table of the go-to-goal controller.
`default_nettype none
package gtg_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] ACT_GOAL = 2'd0;
  localparam logic [1:0] ACT_ODOM = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SPEED_GAIN = 2'd0;
  localparam logic [1:0] REG_TURN_GAIN  = 2'd1;
  localparam logic [1:0] REG_NOM_SPEED  = 2'd2;

  // Rotator settings
  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int NumSteps    = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW       = 5;

  localparam int XW = 36;   // rotator x/y width
  localparam int ZW = 34;   // angle accumulator width, Q30

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [23:0]          INV_K_Q24   = 24'd10188014;
  localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [17:0]   TWO_PI_Q13  = 18'sd51472;

  // One tick command handed from the front to the back
  typedef struct packed {
    logic               fresh;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] yaw;
  } job_t;

  // Arctangent of 2^-i, Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [StepW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage
`default_nettype wire

### hdl/go_to_goal_velocity_command_unit.sv
// Top level of the go-to-goal velocity controller.
//
//  channel  dir  tdata (low bit up)                       tuser
//  in_      in   coord_x[31:0] coord_y[63:32] heading[79:64] action[1:0]
//  out_     out  linear_velocity[23:0] angular_velocity[47:24] fresh
//  cfg_     in   index 0 speed_gain, 1 turn_gain, 2 nominal_speed
//
// A fresh tick goes through setup, the 16 CORDIC iterations (S_ITER),
// the split 1/K multiply (S_MLO, S_MHI), the gains (S_FIN) and the output.
// A stale tick goes from setup to the output. Only ticks are queued.
// Reset is synchronous, active low. A two-entry queue decouples intake from
// the back end; the output register holds a result until taken.
`default_nettype none
module go_to_goal_velocity_command_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [79:0] in_tdata,   // coord_x, coord_y, heading
  input  wire  [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // linear_velocity, angular_velocity
  output logic        out_tuser,  // fresh
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [23:0] cfg_wdata
);
  import gtg_pkg::*;

  logic [15:0] speed_gain_r, turn_gain_r;
  logic [23:0] nom_speed_r;
  logic        push, pop, q_full, q_empty;
  job_t        push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gain_r <= 16'd128;
      turn_gain_r  <= 16'd256;
      nom_speed_r  <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_GAIN: speed_gain_r <= cfg_wdata[15:0];
        REG_TURN_GAIN:  turn_gain_r  <= cfg_wdata[15:0];
        REG_NOM_SPEED:  nom_speed_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gtg_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .push, .push_data, .q_full
  );

  gtg_fifo u_fifo (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .empty(q_empty), .pop_data
  );

  gtg_back u_back (
    .clk, .rst_n, .q_empty, .job(pop_data), .pop,
    .speed_gain(speed_gain_r), .turn_gain(turn_gain_r), .nominal_speed(nom_speed_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule
`default_nettype wire

### hdl/gtg_fifo.sv
// Two-entry queue of tick commands between the front and the back.
`default_nettype none
module gtg_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  gtg_pkg::job_t     push_data,
  output logic              full,
  input  wire               pop,
  output logic              empty,
  output gtg_pkg::job_t     pop_data
);
  import gtg_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### hdl/gtg_front.sv
// Front end: accepts items, keeps goal and pose, queues tick commands.
`default_nettype none
module gtg_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [79:0]        in_tdata,
  input  wire  [1:0]         in_tuser,
  output logic               push,
  output gtg_pkg::job_t      push_data,
  input  wire                q_full
);
  import gtg_pkg::*;

  logic signed [31:0] goal_x_r, goal_y_r, rob_x_r, rob_y_r;
  logic signed [15:0] rob_yaw_r;
  logic               goal_seen_r, odom_seen_r;
  logic               acc;
  logic signed [31:0] cx, cy;

  assign in_tready = ~q_full;
  assign acc       = in_tvalid & in_tready;
  assign cx        = $signed(in_tdata[31:0]);
  assign cy        = $signed(in_tdata[63:32]);

  // Queue a tick with the differences taken now
  assign push           = acc && (in_tuser == ACT_TICK);
  assign push_data.fresh = goal_seen_r & odom_seen_r;
  assign push_data.dx    = {goal_x_r[31], goal_x_r} - {rob_x_r[31], rob_x_r};
  assign push_data.dy    = {goal_y_r[31], goal_y_r} - {rob_y_r[31], rob_y_r};
  assign push_data.yaw   = rob_yaw_r;

  // Hold pose, and the goal once odometry has been seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      rob_x_r     <= '0;
      rob_y_r     <= '0;
      rob_yaw_r   <= '0;
      goal_seen_r <= 1'b0;
      odom_seen_r <= 1'b0;
    end else if (acc) begin
      if (in_tuser == ACT_GOAL && odom_seen_r) begin
        goal_x_r    <= cx;
        goal_y_r    <= cy;
        goal_seen_r <= 1'b1;
      end
      if (in_tuser == ACT_ODOM) begin
        rob_x_r     <= cx;
        rob_y_r     <= cy;
        rob_yaw_r   <= $signed(in_tdata[79:64]);
        odom_seen_r <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/gtg_back.sv
// Back end: CORDIC vectoring, gain multiplies, clipping and the output register.
`default_nettype none
module gtg_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_empty,
  input  gtg_pkg::job_t      job,
  output logic               pop,
  input  wire  [15:0]        speed_gain,
  input  wire  [15:0]        turn_gain,
  input  wire  [23:0]        nominal_speed,
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [47:0]        out_tdata,
  output logic               out_tuser
);
  import gtg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ITER = 6'b000010,
    S_MLO  = 6'b000100,
    S_MHI  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic signed [XW-1:0]  x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic [StepW-1:0]      step_r;
  logic                  zero_r, fresh_r;
  logic signed [15:0]    yaw_r;
  logic [41:0]           plo_r;
  logic [34:0]           dist_r;
  logic [43:0]           lin_r;
  logic [23:0]           ang_r;
  logic [23:0]           last_lin_r, last_ang_r;
  logic                  out_valid_r;
  logic [47:0]           out_data_r;
  logic                  out_user_r;

  logic signed [XW-1:0]  xs, ys, dx_e, dy_e;
  logic [59:0]           mag_sum;
  logic signed [16:0]    yaw_des;
  logic signed [17:0]    err;
  logic signed [34:0]    ang_prod;
  logic [51:0]           lin_prod;
  logic [23:0]           lin_clip;
  logic                  slot_free;

  assign dx_e = XW'(job.dx);
  assign dy_e = XW'(job.dy);
  assign xs   = x_r >>> step_r;
  assign ys   = y_r >>> step_r;
  assign slot_free = ~out_valid_r | out_tready;
  assign pop  = (state_r == S_IDLE) && !q_empty;

  // Magnitude scale: split the multiply by 1/K over S_MLO and S_MHI
  assign mag_sum = {(42'(x_r[35:18]) * INV_K_Q24), 18'b0} + {18'b0, plo_r} + 60'd8388608;

  // Heading error wrapped into +-pi, then gains
  always_comb begin
    yaw_des = zero_r ? 17'sd0 : 17'((z_r + 34'sd65536) >>> 17);
    err = 18'(yaw_des) - 18'(yaw_r);
    if (err > PI_Q13)        err = err - TWO_PI_Q13;
    else if (err < -PI_Q13)  err = err + TWO_PI_Q13;
    if (err > PI_Q13)        err = err - TWO_PI_Q13;
    else if (err < -PI_Q13)  err = err + TWO_PI_Q13;
    ang_prod = $signed({1'b0, turn_gain}) * err + 35'sd128;
    lin_prod = dist_r * speed_gain + 52'd128;
    lin_clip = (lin_r > {20'b0, nominal_speed}) ? nominal_speed : lin_r[23:0];
  end

  // Sequence one tick
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = job.fresh ? S_ITER : S_OUT;
      S_ITER: if (step_r == StepW'(NumSteps - 1)) state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        fresh_r <= job.fresh;
        yaw_r   <= job.yaw;
        zero_r  <= (job.dx == '0) && (job.dy == '0);
        step_r  <= '0;
        if (job.dx < 0) begin
          if (job.dy >= 0) begin
            x_r <= dy_e; y_r <= -dx_e; z_r <= HALF_PI_Q30;
          end else begin
            x_r <= -dy_e; y_r <= dx_e; z_r <= -HALF_PI_Q30;
          end
        end else begin
          x_r <= dx_e; y_r <= dy_e; z_r <= '0;
        end
      end
      S_ITER: begin
        step_r <= step_r + 1'b1;
        if (y_r >= 0) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_q30(step_r);
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_q30(step_r);
        end
      end
      S_MLO: plo_r  <= x_r[17:0] * INV_K_Q24;
      S_MHI: dist_r <= mag_sum[58:24];
      S_FIN: begin
        lin_r <= lin_prod[51:8];
        ang_r <= ang_prod[31:8];
      end
      default: ;
    endcase
  end

  // Load the output register and the last command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_lin_r  <= '0;
      last_ang_r  <= '0;
    end else begin
      if (out_tready) out_valid_r <= 1'b0;
      if (state_r == S_OUT && slot_free) begin
        out_valid_r <= 1'b1;
        if (fresh_r) begin
          last_lin_r <= lin_clip;
          last_ang_r <= ang_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && slot_free) begin
      out_data_r <= fresh_r ? {ang_r, lin_clip} : {last_ang_r, last_lin_r};
      out_user_r <= fresh_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule
`default_nettype wire

### hdl/gtg_checker.sv
// Port-level checks of the go-to-goal controller and their binding.
`default_nettype none
module gtg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [47:0] out_tdata,
  input wire        out_tuser
);
  // No result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // A stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Turn rate bounded by the wrapped heading error
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[47:24]) <= 24'sd6588324) &&
                   ($signed(out_tdata[47:24]) >= -24'sd6588324))
    else $error("angular velocity out of range");

  // A repeated command right after a stale one is the same command
  a_stale_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser ##1 out_tvalid && !out_tuser
      |-> out_tdata == $past(out_tdata))
    else $error("stale command differs from last");
endmodule

bind go_to_goal_velocity_command_unit gtg_checker u_gtg_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
`default_nettype wire
